[rtl/sssd_pkg.sv]
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, constants and helper functions of the seven-segment scan
// driver: request modes, queue entry layout, decimal split and segment table.
// ----------------------------------------------------------------------------
package sssd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   localparam logic [15:0] VALUE_LIMIT = 16'd9999;
   localparam logic [13:0] VALUE_MAX   = 14'd9999;
   localparam logic [13:0] UNIT_THOU   = 14'd1000;
   localparam logic [13:0] UNIT_HUND   = 14'd100;
   localparam logic [13:0] UNIT_TEN    = 14'd10;
   localparam logic [1:0]  SLOT_LAST   = 2'd3;

   typedef enum logic [2:0] {
      MODE_NUM_LO = 3'd0,
      MODE_NUM_HI = 3'd1,
      MODE_RAW_LO = 3'd2,
      MODE_RAW_HI = 3'd3,
      MODE_DOT_HI = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_NUM,
      KIND_RAW,
      KIND_DOT
   } kind_type;

   // one classified request as it waits between front and back
   typedef struct packed {
      kind_type        kind;
      logic            high;
      logic [1:0]      dpos;
      logic [3:0]      enable;
      logic [3:0][7:0] segs;
   } entry_type;

   // largest decimal digit d with d * unit <= v, independent compares
   function automatic logic [3:0] div_digit(input logic [13:0] v,
                                            input logic [13:0] unit);
      logic [3:0] d;
      d = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (v >= 14'(k) * unit) begin
            d = 4'(k);
         end
      end
      return d;
   endfunction

   function automatic logic [7:0] seg_encode(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'h3f;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5b;
         4'd3:    seg = 8'h4f;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6d;
         4'd6:    seg = 8'h7d;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h6f;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

[rtl/sssd_front.sv]
// ----------------------------------------------------------------------------
// sssd_front
// Accepts requests, drops unused modes, saturates the value and splits it
// into decimal digits over three stages, then writes one entry to the queue.
// ----------------------------------------------------------------------------
module sssd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          req_mode,
   input  logic [15:0]         req_value,
   input  logic [31:0]         req_raw,
   input  logic [1:0]          req_dpos,
   input  logic                queue_full,
   output logic                push,
   output sssd_pkg::entry_type push_entry
);

   typedef struct packed {
      sssd_pkg::kind_type kind;
      logic               high;
      logic [1:0]         dpos;
      logic [31:0]        raw;
      logic [13:0]        rem;
      logic [3:0]         d_thou;
      logic [3:0]         d_hund;
   } front_stage_type;

   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic            s1_valid_in;
   front_stage_type s1_ff, s2_ff, s3_ff;
   front_stage_type s1_in, s2_in, s3_in;
   logic            advance;
   logic [3:0]      d_ten, d_one;
   logic [13:0]     rem_one;
   logic [3:0]      show;

   // whole pipe moves together, held only while the queue is full
   assign advance    = !s3_valid_ff || !queue_full;
   assign req_tready = advance;
   assign push       = s3_valid_ff && !queue_full;

   always_comb begin
      s1_in        = '0;
      s1_valid_in  = 1'b0;
      s1_in.high   = req_mode[0];
      s1_in.dpos   = req_dpos;
      s1_in.raw    = req_raw;
      s1_in.rem    = (req_value > sssd_pkg::VALUE_LIMIT) ? sssd_pkg::VALUE_MAX
                                                          : req_value[13:0];
      case (sssd_pkg::mode_type'(req_mode))
         sssd_pkg::MODE_NUM_LO, sssd_pkg::MODE_NUM_HI: begin
            s1_in.kind  = sssd_pkg::KIND_NUM;
            s1_valid_in = req_tvalid;
         end
         sssd_pkg::MODE_RAW_LO, sssd_pkg::MODE_RAW_HI: begin
            s1_in.kind  = sssd_pkg::KIND_RAW;
            s1_valid_in = req_tvalid;
         end
         sssd_pkg::MODE_DOT_HI: begin
            s1_in.kind  = sssd_pkg::KIND_DOT;
            s1_valid_in = req_tvalid;
         end
         // unused modes are taken and dropped
         default: begin
            s1_in.kind  = sssd_pkg::KIND_NUM;
            s1_valid_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      s2_in        = s1_ff;
      s2_in.d_thou = sssd_pkg::div_digit(s1_ff.rem, sssd_pkg::UNIT_THOU);
      s2_in.rem    = s1_ff.rem - (14'(s2_in.d_thou) * sssd_pkg::UNIT_THOU);
   end

   always_comb begin
      s3_in        = s2_ff;
      s3_in.d_hund = sssd_pkg::div_digit(s2_ff.rem, sssd_pkg::UNIT_HUND);
      s3_in.rem    = s2_ff.rem - (14'(s3_in.d_hund) * sssd_pkg::UNIT_HUND);
   end

   always_comb begin
      d_ten   = sssd_pkg::div_digit(s3_ff.rem, sssd_pkg::UNIT_TEN);
      rem_one = s3_ff.rem - (14'(d_ten) * sssd_pkg::UNIT_TEN);
      d_one   = rem_one[3:0];
      // leading zeros blank, ones digit always shows
      show[0] = (s3_ff.d_thou != 4'd0);
      show[1] = show[0] || (s3_ff.d_hund != 4'd0);
      show[2] = show[1] || (d_ten != 4'd0);
      show[3] = 1'b1;

      push_entry      = '0;
      push_entry.kind = s3_ff.kind;
      push_entry.high = s3_ff.high;
      push_entry.dpos = s3_ff.dpos;
      case (s3_ff.kind)
         sssd_pkg::KIND_NUM: begin
            push_entry.enable  = show;
            push_entry.segs[0] = show[0] ? sssd_pkg::seg_encode(s3_ff.d_thou) : 8'h00;
            push_entry.segs[1] = show[1] ? sssd_pkg::seg_encode(s3_ff.d_hund) : 8'h00;
            push_entry.segs[2] = show[2] ? sssd_pkg::seg_encode(d_ten) : 8'h00;
            push_entry.segs[3] = sssd_pkg::seg_encode(d_one);
         end
         sssd_pkg::KIND_RAW: begin
            push_entry.enable = 4'hf;
            push_entry.segs   = s3_ff.raw;
         end
         default: begin
            push_entry.enable = 4'hf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

endmodule

[rtl/sssd_queue.sv]
// ----------------------------------------------------------------------------
// sssd_queue
// Short first-in first-out queue of classified requests between the front
// and the back, so either side can stall on its own.
// ----------------------------------------------------------------------------
module sssd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sssd_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output sssd_pkg::entry_type head
);

   sssd_pkg::entry_type              entries_ff [sssd_pkg::QUEUE_DEPTH];
   logic [sssd_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sssd_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sssd_pkg::CNT_W-1:0]       count_ff, count_in;

   assign full  = (count_ff == sssd_pkg::CNT_W'(sssd_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/sssd_back.sv]
// ----------------------------------------------------------------------------
// sssd_back
// Walks the queue head slot by slot and drives one scan slot per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module sssd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  sssd_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_enable,
   output logic [2:0]          rsp_position,
   output logic [7:0]          rsp_segments,
   output logic                rsp_dot,
   output logic                rsp_tlast
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic       enable_ff, enable_in;
   logic [2:0] position_ff, position_in;
   logic [7:0] segments_ff, segments_in;
   logic       dot_ff, dot_in;
   logic       last_ff, last_in;
   logic [1:0] slot_ff, slot_in;
   logic       take;

   assign take = (!rsp_valid_ff || rsp_tready) && !empty;

   always_comb begin
      enable_in   = head.enable[slot_ff];
      position_in = {head.high, slot_ff};
      segments_in = head.segs[slot_ff];
      dot_in      = 1'b0;
      last_in     = (slot_ff == sssd_pkg::SLOT_LAST);
      case (head.kind)
         sssd_pkg::KIND_DOT: begin
            enable_in   = 1'b1;
            position_in = {1'b1, head.dpos};
            segments_in = 8'h00;
            dot_in      = 1'b1;
            last_in     = 1'b1;
         end
         default: begin
         end
      endcase
      pop          = take && last_in;
      slot_in      = slot_ff;
      if (take) begin
         slot_in = pop ? 2'd0 : slot_ff + 1'b1;
      end
      rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         enable_ff   <= enable_in;
         position_ff <= position_in;
         segments_ff <= segments_in;
         dot_ff      <= dot_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_enable   = enable_ff;
   assign rsp_position = position_ff;
   assign rsp_segments = segments_ff;
   assign rsp_dot      = dot_ff;
   assign rsp_tlast    = last_ff;

endmodule

[rtl/seven_segment_scan_driver.sv]
// each request passes the front pipe, the queue and the output register in turn
// output: numeric and raw requests give four slots, one per cycle unless stalled;
//    a dot request gives a single slot
// the output register takes one slot per cycle unless stalled and sets the sustained rate
// reset clears the pipe, the queue and the output; items in flight are dropped
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Two-bank multiplexed seven-segment scan driver: classifies requests into
// a queue and emits per-digit scan slots on a stream output.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // value[15:0], raw_segments[47:16], dot_position[49:48]
   input  logic [2:0]  req_tuser,  // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // digit_enable[0], digit_position[3:1], segments[11:4],
                                   // dot_on[12]
   output logic        rsp_tlast
);

   logic                push, pop, full, empty;
   sssd_pkg::entry_type push_entry, head;
   logic                enable, dot;
   logic [2:0]          position;
   logic [7:0]          segments;

   sssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_value  (req_tdata[15:0]),
      .req_raw    (req_tdata[47:16]),
      .req_dpos   (req_tdata[49:48]),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   sssd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   sssd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head         (head),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_enable   (enable),
      .rsp_position (position),
      .rsp_segments (segments),
      .rsp_dot      (dot),
      .rsp_tlast    (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, dot, segments, position, enable};

endmodule

[rtl/sssd_checker.sv]
// ----------------------------------------------------------------------------
// sssd_checker
// Port-level checks of the scan driver output, bound to the top level.
// ----------------------------------------------------------------------------
module sssd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled slot holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled slot changed");

   // blank slots carry no segments and no dot
   a_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[11:4] == 8'h00 && !rsp_tdata[12])
      else $error("blank slot drives segments");

   // a dot slot is a single high-bank slot with no segments
   a_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12]
         |-> rsp_tdata[0] && rsp_tdata[3] && rsp_tlast && rsp_tdata[11:4] == 8'h00)
      else $error("bad dot slot");

   // final slot of a run is the ones digit and always shows
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tdata[12] |-> rsp_tdata[0] && rsp_tdata[2:1] == 2'b11)
      else $error("bad final slot");

endmodule

bind seven_segment_scan_driver sssd_checker u_sssd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
